>>> rtl/ftcb_pkg.sv
package ftcb_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam logic [31:0] BUDGET_RESET = 32'd256 * 32'd1024 * 32'd1024;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_PRESENT   = 3'd1;
    localparam logic [2:0] KIND_TOO_LARGE = 3'd2;
    localparam logic [2:0] KIND_HIT       = 3'd3;
    localparam logic [2:0] KIND_MISS      = 3'd4;
    localparam logic [2:0] KIND_EVICTED   = 3'd5;
    localparam logic [2:0] KIND_REMOVED   = 3'd6;
    localparam logic [2:0] KIND_DONE      = 3'd7;

    // request: opcode, id, size, handle from bit 0 up
    localparam int IN_W  = 2 + 96;
    localparam int IN_TW = 104;
    // result: kind, id, size, handle
    localparam int OUT_W  = 3 + 96;
    localparam int OUT_TW = 104;

endpackage

>>> rtl/ftcb_ram.sv
module ftcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/fifo_tile_cache_byte_budget.sv
// Channel | Dir | Handshake            | Payload
// s_axis  | in  | tvalid/tready        | tdata: opcode, tile_id, tile_size, data_handle
// m_axis  | out | tvalid/tready, tlast | tdata: result_kind, out_tile_id, out_tile_size, out_handle
// cfg     | in  | i_cfg_we             | i_cfg_wdata: cache_budget_bytes
// One request at a time; an id search reads the slot RAM entry by entry (ST_SRD, ST_SCHK).
// Each eviction walks the age queue (shifted one entry per cycle), and so does a remove.
// s_axis_tready is high only while the sequencer is idle.
// Reset (i_rst_n low, synchronous) empties the cache and restores the budget.
// A stalled result holds its register until taken; states that load a new result wait too.
module fifo_tile_cache_byte_budget #(
    parameter int ENTRIES = ftcb_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [31:0]                 i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ftcb_pkg::IN_TW-1:0]  s_axis_tdata,  // opcode, tile_id, tile_size, data_handle
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ftcb_pkg::OUT_TW-1:0] m_axis_tdata,  // kind, id, size, handle
    output logic                        m_axis_tlast
);
    import ftcb_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRD, ST_SCHK, ST_FIT, ST_ERD, ST_EWAIT, ST_EOUT,
        ST_SHIFT, ST_INS, ST_OUT
    } t_state;

    t_state r_state;
    logic [31:0] r_budget, r_bytes;
    logic [CW-1:0] r_count;
    logic [ENTRIES-1:0] r_valid;
    logic [1:0] r_op;
    logic [31:0] r_id, r_size, r_handle;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_victim;
    logic r_clear_done;
    logic r_found;
    logic r_ovalid, r_olast;
    logic [2:0] r_okind;
    logic [31:0] r_oid, r_osize, r_ohandle;

    logic [AW-1:0] slot_raddr, age_raddr, age_waddr, slot_waddr;
    logic slot_we, age_we;
    logic [AW-1:0] age_wdata;
    logic [31:0] rd_id, rd_size, rd_handle;
    logic [AW-1:0] rd_age;
    logic [AW-1:0] free_slot;
    logic [31:0] free_b;
    logic out_busy, n_ovalid;

    ftcb_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_id (.i_clk, .i_we(slot_we),
        .i_waddr(slot_waddr), .i_wdata(r_id), .i_raddr(slot_raddr), .o_rdata(rd_id));
    ftcb_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_size (.i_clk, .i_we(slot_we),
        .i_waddr(slot_waddr), .i_wdata(r_size), .i_raddr(slot_raddr), .o_rdata(rd_size));
    ftcb_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_hdl (.i_clk, .i_we(slot_we),
        .i_waddr(slot_waddr), .i_wdata(r_handle), .i_raddr(slot_raddr),
        .o_rdata(rd_handle));
    ftcb_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_age (.i_clk, .i_we(age_we),
        .i_waddr(age_waddr), .i_wdata(age_wdata), .i_raddr(age_raddr), .o_rdata(rd_age));

    always_comb begin
        free_slot = '0;
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_slot = AW'(k);
            end
        end
    end

    assign free_b = (r_budget > r_bytes) ? r_budget - r_bytes : 32'd0;

    assign out_busy = r_ovalid && !m_axis_tready;

    always_comb begin
        n_ovalid = out_busy;
        if ((r_state == ST_EOUT || r_state == ST_OUT) && !out_busy) begin
            n_ovalid = 1'b1;
        end
    end

    // read addresses: search uses r_idx as slot, evict/shift use age queue
    always_comb begin
        slot_raddr = r_idx[AW-1:0];
        age_raddr  = r_idx[AW-1:0];
        if (r_state == ST_EWAIT) begin
            slot_raddr = rd_age;
        end
        if (r_state == ST_EOUT) begin
            slot_raddr = r_victim;
        end
        if (r_state == ST_SHIFT) begin
            age_raddr = (r_idx + CW'(1) < CW'(ENTRIES)) ? AW'(r_idx + CW'(1)) : '0;
        end
        slot_we    = (r_state == ST_INS);
        slot_waddr = free_slot;
        age_we     = 1'b0;
        age_waddr  = r_idx[AW-1:0];
        age_wdata  = rd_age;
        if (r_state == ST_SHIFT && r_found) begin
            age_we    = 1'b1;
            age_waddr = AW'(r_idx - CW'(1));
        end
        if (r_state == ST_INS) begin
            age_we    = 1'b1;
            age_waddr = r_count[AW-1:0];
            age_wdata = free_slot;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'd0, r_ohandle, r_osize, r_oid, r_okind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_budget <= BUDGET_RESET;
            r_bytes  <= '0;
            r_count  <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
            r_ovalid <= n_ovalid;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op     <= s_axis_tdata[1:0];
                        r_id     <= s_axis_tdata[33:2];
                        r_size   <= s_axis_tdata[65:34];
                        r_handle <= s_axis_tdata[97:66];
                        r_idx    <= '0;
                        r_state  <= (s_axis_tdata[1:0] == OP_CLEAR) ? ST_FIT : ST_SRD;
                    end
                end
                ST_SRD: begin
                    r_state <= ST_SCHK;
                end
                ST_SCHK: begin
                    if (!out_busy) begin
                        if (r_valid[r_idx[AW-1:0]] && rd_id == r_id) begin
                            r_victim <= r_idx[AW-1:0];
                            r_oid <= r_id;
                            r_osize <= rd_size;
                            r_ohandle <= rd_handle;
                            r_olast <= 1'b1;
                            if (r_op == OP_REMOVE) begin
                                r_okind <= KIND_REMOVED;
                                r_valid[r_idx[AW-1:0]] <= 1'b0;
                                r_bytes <= r_bytes - rd_size;
                                r_idx <= '0;
                                r_clear_done <= 1'b1;
                                r_state <= ST_EWAIT;
                            end else begin
                                r_okind <= (r_op == OP_ADD) ? KIND_PRESENT : KIND_HIT;
                                r_state <= ST_OUT;
                            end
                        end else if (r_idx == CW'(ENTRIES - 1)) begin
                            if (r_op == OP_ADD) begin
                                r_state <= ST_FIT;
                            end else begin
                                r_okind <= KIND_MISS;
                                r_oid <= r_id;
                                r_osize <= '0;
                                r_ohandle <= '0;
                                r_olast <= 1'b1;
                                r_state <= ST_OUT;
                            end
                        end else begin
                            r_idx <= r_idx + CW'(1);
                            r_state <= ST_SRD;
                        end
                    end
                end
                ST_FIT: begin
                    if (!out_busy) begin
                        r_idx <= '0;
                        r_clear_done <= 1'b0;
                        if (r_op == OP_CLEAR) begin
                            if (r_count == '0) begin
                                r_okind <= KIND_DONE;
                                r_oid <= '0;
                                r_osize <= '0;
                                r_ohandle <= '0;
                                r_olast <= 1'b1;
                                r_state <= ST_OUT;
                            end else begin
                                r_state <= ST_ERD;
                            end
                        end else if (free_b < r_size) begin
                            if (r_count == '0) begin
                                r_okind <= KIND_TOO_LARGE;
                                r_oid <= r_id;
                                r_osize <= r_size;
                                r_ohandle <= r_handle;
                                r_olast <= 1'b1;
                                r_state <= ST_OUT;
                            end else begin
                                r_state <= ST_ERD;
                            end
                        end else if (r_count >= CW'(ENTRIES)) begin
                            r_state <= ST_ERD;
                        end else begin
                            r_state <= ST_INS;
                        end
                    end
                end
                ST_ERD: begin
                    // age queue head read this cycle
                    r_state <= ST_EWAIT;
                end
                ST_EWAIT: begin
                    if (r_clear_done) begin
                        // removal: find victim in age queue
                        r_state <= ST_SHIFT;
                        r_idx <= '0;
                        r_found <= 1'b0;
                    end else begin
                        r_victim <= rd_age;
                        r_state <= ST_EOUT;
                    end
                end
                ST_EOUT: begin
                    if (!out_busy) begin
                        r_okind <= KIND_EVICTED;
                        r_oid <= rd_id;
                        r_osize <= rd_size;
                        r_ohandle <= rd_handle;
                        r_olast <= 1'b0;
                        r_valid[r_victim] <= 1'b0;
                        r_bytes <= r_bytes - rd_size;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    // r_idx walks the queue; past the victim, entries move down
                    if (rd_age == r_victim) begin
                        r_found <= 1'b1;
                    end
                    if (r_idx + CW'(1) >= r_count) begin
                        r_count <= r_count - CW'(1);
                        if (r_clear_done) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_FIT;
                        end
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_INS: begin
                    if (!out_busy) begin
                        r_valid[free_slot] <= 1'b1;
                        r_count <= r_count + CW'(1);
                        r_bytes <= r_bytes + r_size;
                        r_okind <= KIND_ADDED;
                        r_oid <= r_id;
                        r_osize <= r_size;
                        r_ohandle <= r_handle;
                        r_olast <= 1'b1;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!out_busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_bytes_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && r_state == ST_IDLE) |-> r_valid == '0) else $error("valid left");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == ST_IDLE) else $error("ready");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES)) else $error("count");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");
endmodule

>>> verif/tb_fifo_tile_cache_byte_budget.sv
module tb_fifo_tile_cache_byte_budget;
    timeunit 1ns;
    timeprecision 1ps;
    import ftcb_pkg::*;

    localparam int NSLOT = ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] handle;
        logic [31:0] size;
        logic [31:0] id;
        logic [1:0]  op;
    } tile_req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [31:0] size;
        logic [31:0] handle;
        logic        last;
    } tile_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TW-1:0] s_axis_tdata = '0;  // opcode, tile_id, tile_size, data_handle
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;      // kind, id, size, handle
    logic m_axis_tlast;

    fifo_tile_cache_byte_budget dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [31:0] budget;
    logic        c_valid [NSLOT];
    logic [31:0] c_id [NSLOT];
    logic [31:0] c_size [NSLOT];
    logic [31:0] c_handle [NSLOT];
    int          c_age [$];
    logic [31:0] c_bytes;

    tile_req_t  req_q [$];
    tile_res_t  expected_q [$];
    int sender_idle = 19, receiver_idle = 49;
    int hold_cycles = 0;
    int mismatches = 0, results_seen = 0, reqs_sent = 0, cycles = 0;
    int n_evict = 0, n_large = 0;

    function automatic int find_tile(logic [31:0] id);
        for (int s = 0; s < NSLOT; s++)
            if (c_valid[s] && c_id[s] == id) return s;
        return -1;
    endfunction

    function automatic void post(logic [2:0] k, logic [31:0] id, logic [31:0] sz,
                                 logic [31:0] h, logic l);
        tile_res_t r;
        r.kind = k; r.id = id; r.size = sz; r.handle = h; r.last = l;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void drop_tile(int s);
        c_valid[s] = 1'b0;
        c_bytes -= c_size[s];
        for (int i = 0; i < c_age.size(); i++)
            if (c_age[i] == s) begin
                c_age.delete(i);
                break;
            end
    endfunction

    function automatic void evict_oldest();
        int s;
        s = c_age[0];
        post(KIND_EVICTED, c_id[s], c_size[s], c_handle[s], 1'b0);
        n_evict++;
        drop_tile(s);
    endfunction

    function automatic logic [31:0] free_bytes();
        return (budget > c_bytes) ? budget - c_bytes : 32'd0;
    endfunction

    function automatic void predict_cache(tile_req_t q);
        int s;
        s = find_tile(q.id);
        case (q.op)
            OP_ADD: begin
                if (s >= 0) begin
                    post(KIND_PRESENT, q.id, c_size[s], c_handle[s], 1'b1);
                    return;
                end
                while (free_bytes() < q.size) begin
                    if (c_age.size() == 0) begin
                        post(KIND_TOO_LARGE, q.id, q.size, q.handle, 1'b1);
                        n_large++;
                        return;
                    end
                    evict_oldest();
                end
                if (c_age.size() >= NSLOT) evict_oldest();
                for (s = 0; s < NSLOT; s++)
                    if (!c_valid[s]) break;
                c_valid[s] = 1'b1; c_id[s] = q.id; c_size[s] = q.size;
                c_handle[s] = q.handle;
                c_age.insert(c_age.size(), s);
                c_bytes += q.size;
                post(KIND_ADDED, q.id, q.size, q.handle, 1'b1);
            end
            OP_REMOVE: begin
                if (s >= 0) begin
                    post(KIND_REMOVED, q.id, c_size[s], c_handle[s], 1'b1);
                    drop_tile(s);
                end else post(KIND_MISS, q.id, 32'd0, 32'd0, 1'b1);
            end
            OP_LOOKUP: begin
                if (s >= 0) post(KIND_HIT, q.id, c_size[s], c_handle[s], 1'b1);
                else post(KIND_MISS, q.id, 32'd0, 32'd0, 1'b1);
            end
            default: begin
                while (c_age.size() > 0) evict_oldest();
                post(KIND_DONE, 32'd0, 32'd0, 32'd0, 1'b1);
            end
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_cache(tile_req_t'(s_axis_tdata[IN_W-1:0]));
                reqs_sent++;
                void'(req_q.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_q.size() > 0 &&
                    !(sender_idle > 0 && $urandom_range(99) < sender_idle)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(IN_TW-IN_W){1'b0}}, req_q[0]};
                end else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        tile_res_t got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind   = m_axis_tdata[2:0];
                got.id     = m_axis_tdata[34:3];
                got.size   = m_axis_tdata[66:35];
                got.handle = m_axis_tdata[OUT_W-1:67];
                got.last   = m_axis_tlast;
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: kind %0d/%0d id %h/%h size %h/%h",
                                      " handle %h/%h last %b/%b (exp/act)"},
                                     want.kind, got.kind, want.id, got.id,
                                     want.size, got.size, want.handle, got.handle,
                                     want.last, got.last);
                    end
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else
                m_axis_tready <= !(receiver_idle > 0 && $urandom_range(99) < receiver_idle);
        end
    end

    function automatic tile_req_t mk(logic [1:0] op, logic [31:0] id, logic [31:0] sz,
                                     logic [31:0] h);
        tile_req_t q;
        q.op = op; q.id = id; q.size = sz; q.handle = h;
        return q;
    endfunction

    function automatic void enqueue(tile_req_t q);
        req_q.insert(req_q.size(), q);
    endfunction

    task automatic drain();
        while (req_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_budget(logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        budget = v;
    endtask

    task automatic random_batch(int n, int id_span, int size_max);
        logic [1:0] op;
        logic [31:0] id, sz;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(99) < 55) ? OP_ADD :
                 ($urandom_range(99) < 98) ? 2'($urandom_range(1, 2)) : OP_CLEAR;
            id = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(id_span));
            case ($urandom_range(9))
                0: sz = $urandom();
                1: sz = 32'd0;
                default: sz = 32'($urandom_range(size_max));
            endcase
            enqueue(mk(op, id, sz, $urandom()));
        end
    endtask

    initial begin
        budget = BUDGET_RESET;
        c_bytes = '0;
        for (int s = 0; s < NSLOT; s++) c_valid[s] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        enqueue(mk(OP_LOOKUP, 32'd5, 32'd0, 32'd0));
        enqueue(mk(OP_REMOVE, 32'hFFFFFFFF, 32'd0, 32'd0));
        enqueue(mk(OP_ADD, 32'd0, 32'd0, 32'hFFFFFFFF));
        enqueue(mk(OP_ADD, 32'hFFFFFFFF, 32'd1024, 32'h0));
        enqueue(mk(OP_ADD, 32'd0, 32'd7, 32'd7));
        enqueue(mk(OP_LOOKUP, 32'hFFFFFFFF, 32'd0, 32'd0));
        enqueue(mk(OP_ADD, 32'd9, 32'hFFFFFFFF, 32'hA5A5A5A5));
        enqueue(mk(OP_ADD, 32'd10, BUDGET_RESET, 32'h5A5A5A5A));
        enqueue(mk(OP_REMOVE, 32'd10, 32'd0, 32'd0));
        for (int i = 0; i < 12; i++)
            enqueue(mk(OP_ADD, 32'(100 + i), 32'(1024 * i), 32'(i)));
        enqueue(mk(OP_CLEAR, 32'd0, 32'd0, 32'd0));
        enqueue(mk(OP_CLEAR, 32'd0, 32'd0, 32'd0));
        drain();

        // small budget: byte evictions and too-large
        set_budget(32'd4096);
        for (int i = 0; i < 20; i++)
            enqueue(mk(OP_ADD, 32'(200 + i), 32'd1024, 32'(i)));
        enqueue(mk(OP_ADD, 32'd300, 32'd4097, 32'd1));
        sender_idle = 19; receiver_idle = 49;
        random_batch(100, 40, 3000);
        drain();

        // zero budget: only empty tiles fit
        set_budget(32'd0);
        sender_idle = 49; receiver_idle = 19;
        random_batch(60, 30, 4);
        drain();

        // full budget: slot pressure, long receiver hold-off
        set_budget(32'hFFFFFFFF);
        hold_cycles = 400;
        random_batch(110, 60, 100000);
        drain();

        set_budget(32'd20000);
        sender_idle = 0; receiver_idle = 0;
        random_batch(120, 50, 4000);
        drain();

        $display("%0d requests, %0d results, %0d evictions, %0d too-large, 5 budgets",
                 reqs_sent, results_seen, n_evict, n_large);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else begin
            $display("%0d mismatches, %0d outstanding", mismatches, expected_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
